>>> design/r2h_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package r2h_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned HSV_W     = 16;
  localparam int unsigned DELTA6_W  = CH_W + 3;
  localparam int unsigned HUE_NUM_W = DELTA6_W + HSV_W;
  localparam int unsigned SAT_NUM_W = CH_W + HSV_W;
  localparam int unsigned PRE_LAT   = 3;
  localparam int unsigned DIV_LAT   = HSV_W;
  localparam int unsigned TOTAL_LAT = PRE_LAT + DIV_LAT;

  typedef enum logic [1:0] {
    SEG_RED,
    SEG_GREEN,
    SEG_BLUE
  } seg_e;

  typedef struct packed {
    logic [CH_W-1:0] value;
    logic [CH_W-1:0] alpha;
  } side_t;

endpackage

>>> design/r2h_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
module r2h_divider import r2h_pkg::*; #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 11,
  parameter int unsigned Q_W   = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quot_o
);

  // num_i must be below den_i << Q_W; DEN_W + Q_W - 1 must not exceed NUM_W + 1.
  logic [NUM_W-1:0] rem_q  [0:Q_W-2];
  logic [DEN_W-1:0] den_q  [0:Q_W-2];
  logic [Q_W-1:0]   quot_q [0:Q_W-1];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quot_in;
    logic [NUM_W:0]   trial;
    logic [NUM_W-1:0] rem_d;
    logic [Q_W-1:0]   quot_d;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    assign trial  = {1'b0, rem_in}
                  - ({{(NUM_W + 1 - DEN_W){1'b0}}, den_in} << (Q_W - 1 - k));
    assign rem_d  = trial[NUM_W] ? rem_in : trial[NUM_W-1:0];
    assign quot_d = quot_in | ({{(Q_W - 1){1'b0}}, ~trial[NUM_W]} << (Q_W - 1 - k));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_q[k] <= quot_d;
      end
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quot_o = quot_q[Q_W-1];

endmodule

>>> design/rgb_to_hsv_converter.sv
// RGB to HSV converter top level: prep stages, two dividers, output valid chain.
//
// Accepts one RGBA pixel per clock while not stalled and returns hue,
// saturation, value and the passed-through alpha: three stages find
// max/min, the hue segment and the division operands, then two 16-stage
// restoring dividers (one quotient bit per stage) produce hue and saturation
// side by side. The whole pipe advances when the output register is empty or
// being taken, so a stalled output holds every stage and nothing is lost.
module rgb_to_hsv_converter import r2h_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CH_W-1:0] red_in_i,
  input  logic [CH_W-1:0] green_in_i,
  input  logic [CH_W-1:0] blue_in_i,
  input  logic [CH_W-1:0] alpha_in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [HSV_W-1:0] hue_out_o,
  output logic [HSV_W-1:0] sat_out_o,
  output logic [CH_W-1:0] value_out_o,
  output logic [CH_W-1:0] alpha_out_o
);

  logic en;
  logic [TOTAL_LAT-1:0] vld_q;

  assign en         = ~vld_q[TOTAL_LAT-1] | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], in_valid_i};
    end
  end

  // stage 1: max, min, segment
  logic [CH_W-1:0] mx_d, mn_d;
  seg_e            seg_d;
  logic [CH_W-1:0] r1_q, g1_q, b1_q, a1_q, mx1_q, mn1_q;
  seg_e            seg1_q;

  always_comb begin
    mx_d = red_in_i;
    mn_d = red_in_i;
    if (green_in_i > mx_d) mx_d = green_in_i;
    if (blue_in_i > mx_d) mx_d = blue_in_i;
    if (green_in_i < mn_d) mn_d = green_in_i;
    if (blue_in_i < mn_d) mn_d = blue_in_i;
    if (red_in_i >= green_in_i && red_in_i >= blue_in_i) begin
      seg_d = SEG_RED;
    end else if (green_in_i >= blue_in_i) begin
      seg_d = SEG_GREEN;
    end else begin
      seg_d = SEG_BLUE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q   <= red_in_i;
      g1_q   <= green_in_i;
      b1_q   <= blue_in_i;
      a1_q   <= alpha_in_i;
      mx1_q  <= mx_d;
      mn1_q  <= mn_d;
      seg1_q <= seg_d;
    end
  end

  // stage 2: delta and channel difference
  logic [CH_W:0]   diff_d;
  logic [CH_W-1:0] delta2_q, mx2_q, a2_q;
  logic [CH_W:0]   diff2_q;
  seg_e            seg2_q;

  always_comb begin
    case (seg1_q)
      SEG_RED:   diff_d = {1'b0, g1_q} - {1'b0, b1_q};
      SEG_GREEN: diff_d = {1'b0, b1_q} - {1'b0, r1_q};
      SEG_BLUE:  diff_d = {1'b0, r1_q} - {1'b0, g1_q};
      default:   diff_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      delta2_q <= mx1_q - mn1_q;
      diff2_q  <= diff_d;
      mx2_q    <= mx1_q;
      a2_q     <= a1_q;
      seg2_q   <= seg1_q;
    end
  end

  // stage 3: hue numerator and division operands
  logic [CH_W+1:0]     off_d;
  logic [DELTA6_W-1:0] d6_d;
  logic [DELTA6_W:0]   sum_d, wrap_d;
  logic                zero_d;
  logic [HUE_NUM_W-1:0] hnum_q;
  logic [DELTA6_W-1:0]  hden_q;
  logic [SAT_NUM_W-1:0] snum_q;
  logic [CH_W-1:0]      sden_q;
  side_t                side3_q;

  assign zero_d = (delta2_q == '0);
  assign d6_d   = {1'b0, delta2_q, 2'b00} + {2'b00, delta2_q, 1'b0};

  always_comb begin
    case (seg2_q)
      SEG_RED:   off_d = '0;
      SEG_GREEN: off_d = {1'b0, delta2_q, 1'b0};
      SEG_BLUE:  off_d = {delta2_q, 2'b00};
      default:   off_d = '0;
    endcase
    sum_d  = {{(DELTA6_W - CH_W){diff2_q[CH_W]}}, diff2_q} + {2'b00, off_d};
    wrap_d = sum_d[DELTA6_W] ? (sum_d + {1'b0, d6_d}) : sum_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hnum_q  <= {wrap_d[DELTA6_W-1:0], {HSV_W{1'b0}}};
      hden_q  <= zero_d ? DELTA6_W'(1) : d6_d;
      snum_q  <= {delta2_q, {HSV_W{1'b0}}} - {{HSV_W{1'b0}}, delta2_q};
      sden_q  <= zero_d ? CH_W'(1) : mx2_q;
      side3_q <= '{value: mx2_q, alpha: a2_q};
    end
  end

  // divider stages
  r2h_divider #(
    .NUM_W (HUE_NUM_W),
    .DEN_W (DELTA6_W),
    .Q_W   (HSV_W)
  ) u_hue_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (hnum_q),
    .den_i  (hden_q),
    .quot_o (hue_out_o)
  );

  r2h_divider #(
    .NUM_W (SAT_NUM_W),
    .DEN_W (CH_W),
    .Q_W   (HSV_W)
  ) u_sat_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (snum_q),
    .den_i  (sden_q),
    .quot_o (sat_out_o)
  );

  side_t side_q [0:DIV_LAT-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side3_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid_o = vld_q[TOTAL_LAT-1];
  assign value_out_o = side_q[DIV_LAT-1].value;
  assign alpha_out_o = side_q[DIV_LAT-1].alpha;

endmodule

>>> design/r2h_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
module r2h_checker import r2h_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [HSV_W-1:0] hue_out_o,
  input logic [HSV_W-1:0] sat_out_o,
  input logic [CH_W-1:0]  value_out_o,
  input logic [CH_W-1:0]  alpha_out_o
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hue_out_o)
      && $stable(sat_out_o) && $stable(value_out_o) && $stable(alpha_out_o))
    else $error("output beat changed while stalled");

  // empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // zero saturation only for achromatic pixels, which have zero hue
  a_achrom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sat_out_o == '0 |-> hue_out_o == '0)
    else $error("nonzero hue with zero saturation");

  // black is achromatic
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_out_o == '0 |-> sat_out_o == '0)
    else $error("nonzero saturation on black");

endmodule

bind rgb_to_hsv_converter r2h_checker u_r2h_checker (.*);
